// ----- rtl/core/tftp_windowed_session_assert.svh -----
// Assertion macros for the session RTL, used by tws_back.
// Expects clk and rst_n in scope at the point of use.
`ifndef TFTP_WINDOWED_SESSION_ASSERT_SVH
`define TFTP_WINDOWED_SESSION_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tws_pkg.sv -----
// Shared types, codes and constants for the TFTP windowed session block.
// No dependencies.
package tws_pkg;

    localparam logic [15:0] BLK_DEF      = 16'd512;
    localparam logic [15:0] BLK_MAX      = 16'd65464;
    localparam logic [7:0]  TMO_MAX      = 8'd255;
    localparam logic [6:0]  WIN_DEF      = 7'd1;
    localparam int          WINDOW_LIMIT_DEF = 64;

    localparam logic [2:0] KIND_RRQ  = 3'd0;
    localparam logic [2:0] KIND_WRQ  = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_ACK  = 3'd3;
    localparam logic [2:0] KIND_TICK = 3'd4;

    localparam logic [2:0] OST_OK        = 3'd0;
    localparam logic [2:0] OST_NOT_FOUND = 3'd1;
    localparam logic [2:0] OST_ACCESS    = 3'd2;
    localparam logic [2:0] OST_EXISTS    = 3'd3;

    localparam logic [1:0] WST_OK    = 2'd0;
    localparam logic [1:0] WST_QUOTA = 2'd1;

    localparam logic [1:0] PT_DATA  = 2'd0;
    localparam logic [1:0] PT_ACK   = 2'd1;
    localparam logic [1:0] PT_OACK  = 2'd2;
    localparam logic [1:0] PT_ERROR = 2'd3;

    localparam logic [2:0] ERR_UNDEF     = 3'd0;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
    localparam logic [2:0] ERR_ACCESS    = 3'd2;
    localparam logic [2:0] ERR_DISK_FULL = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd4;
    localparam logic [2:0] ERR_EXISTS    = 3'd6;

    localparam logic [1:0] CFG_LIMIT_BLOCK   = 2'd0;
    localparam logic [1:0] CFG_LIMIT_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_LIMIT_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    // One queue entry: either a single control packet or a DATA window.
    typedef struct packed {
        logic        is_window;
        logic [1:0]  ptype;
        logic [15:0] blk;
        logic [2:0]  err;
        logic [15:0] ob;
        logic [6:0]  ow;
        logic [7:0]  ot;
        logic        done;
        logic [23:0] abs_ack;
        logic [6:0]  count;
        logic [15:0] bsize;
        logic [31:0] fsize;
        logic [23:0] fin;
    } cmd_t;

    function automatic cmd_t ctrl_cmd(input logic [1:0] ptype, input logic [15:0] blk,
                                      input logic [2:0] err, input logic [15:0] ob,
                                      input logic [6:0] ow, input logic [7:0] ot,
                                      input logic done);
        cmd_t c;
        c           = '0;
        c.ptype     = ptype;
        c.blk       = blk;
        c.err       = err;
        c.ob        = ob;
        c.ow        = ow;
        c.ot        = ot;
        c.done      = done;
        return c;
    endfunction

endpackage

// ----- rtl/core/tws_div.sv -----
// Restoring divider, one quotient bit per cycle, for the final block number.
// No dependencies; it does not import tws_pkg.
module tws_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] sh;
    logic        ge;

    assign sh = {rem_reg, quo_reg[31]};
    assign ge = sh >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 16'(sh - {1'b0, dvs_reg}) : sh[15:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- rtl/core/tws_front.sv -----
// Front end: accepts packets, keeps session state, negotiates options and
// queues commands for the back end. Depends on tws_pkg and tws_div.
module tws_front
    import tws_pkg::*;
#(
    parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] block_number,
    input  logic [15:0] data_length,
    input  logic [15:0] req_blksize,
    input  logic [15:0] req_windowsize,
    input  logic [15:0] req_timeout,
    input  logic [2:0]  open_status,
    input  logic [31:0] file_length,
    input  logic [1:0]  write_status,
    input  logic [15:0] lim_bs,
    input  logic [6:0]  lim_win,
    input  logic [7:0]  lim_tmo,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_RACK = 3'b100
    } fstate_t;

    localparam logic [6:0] WL = 7'(WINDOW_LIMIT);

    fstate_t     state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [15:0] bs_reg, bs_next;
    logic [6:0]  ws_reg, ws_next;
    logic [15:0] lack_reg, lack_next;
    logic [15:0] lwr_reg, lwr_next;
    logic        fsent_reg, fsent_next;
    logic [7:0]  wrap_reg, wrap_next;
    logic        fin_flag_reg, fin_flag_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [23:0] fin_reg, fin_next;
    logic [15:0] ack_reg, ack_next;
    logic        rpend_reg, rpend_next;

    logic        acc;
    logic        div_start, div_done;
    logic [31:0] div_quo;

    // negotiation
    logic [15:0] lb, nb, ob;
    logic [6:0]  lw, nw, ow;
    logic [7:0]  lt, ot;
    logic        any_opt;

    // read-side acknowledgement
    logic [15:0] d;
    logic [7:0]  rwrap;
    logic [23:0] abs_ack, rem;
    logic        before_fin, reach_fin;
    logic [6:0]  rcnt;
    logic        rdone;
    cmd_t        wcmd;

    // write-side DATA
    logic [15:0] lwr_inc;
    logic        wdone, wack;

    tws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (file_length),
        .divisor  (nb),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_stall = !((state_reg == F_IDLE) && !q_full);
    assign acc      = in_valid && !in_stall;

    assign lb = (lim_bs < BLK_DEF) ? BLK_DEF : ((lim_bs > BLK_MAX) ? BLK_MAX : lim_bs);
    assign lw = (lim_win == 7'd0) ? 7'd1 : ((lim_win > WL) ? WL : lim_win);
    assign lt = (lim_tmo == 8'd0) ? 8'd1 : lim_tmo;
    assign nb = (req_blksize > BLK_DEF)
              ? ((req_blksize < lb) ? req_blksize : lb) : BLK_DEF;
    assign ob = (req_blksize > BLK_DEF) ? nb : 16'd0;
    assign nw = (req_windowsize > 16'd1)
              ? ((req_windowsize < {9'd0, lw}) ? req_windowsize[6:0] : lw) : WIN_DEF;
    assign ow = (req_windowsize > 16'd1) ? nw : 7'd0;
    assign ot = (req_timeout > 16'd1)
              ? ((req_timeout < {8'd0, lt}) ? req_timeout[7:0] : lt) : 8'd0;
    assign any_opt = (req_blksize > BLK_DEF) || (req_windowsize > 16'd1)
                   || (req_timeout > 16'd1);

    // Track 16-bit block wraps in serial arithmetic.
    assign d = ack_reg - lack_reg;
    always_comb
    begin
        rwrap = wrap_reg;
        if (d != 16'd0 && !d[15])
        begin
            if (ack_reg < lack_reg)
                rwrap = wrap_reg + 8'd1;
        end
        else if (d[15])
        begin
            if (ack_reg > lack_reg && wrap_reg != 8'd0)
                rwrap = wrap_reg - 8'd1;
        end
    end

    assign abs_ack    = {rwrap, ack_reg};
    assign before_fin = abs_ack < fin_reg;
    assign rem        = fin_reg - abs_ack;
    assign reach_fin  = before_fin && (rem <= {17'd0, ws_reg});
    assign rcnt       = !before_fin ? 7'd0 : (reach_fin ? rem[6:0] : ws_reg);
    assign rdone      = fin_flag_reg || (fsent_reg && abs_ack == fin_reg);

    always_comb
    begin
        wcmd           = '0;
        wcmd.is_window = 1'b1;
        wcmd.ptype     = PT_DATA;
        wcmd.done      = rdone;
        wcmd.abs_ack   = abs_ack;
        wcmd.count     = rcnt;
        wcmd.bsize     = bs_reg;
        wcmd.fsize     = fsize_reg;
        wcmd.fin       = fin_reg;
    end

    assign lwr_inc = lwr_reg + 16'd1;
    assign wdone   = fin_flag_reg || (data_length < bs_reg);
    assign wack    = wdone || (lwr_inc == 16'(lack_reg + {9'd0, ws_reg}));

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        bs_next       = bs_reg;
        ws_next       = ws_reg;
        lack_next     = lack_reg;
        lwr_next      = lwr_reg;
        fsent_next    = fsent_reg;
        wrap_next     = wrap_reg;
        fin_flag_next = fin_flag_reg;
        fsize_next    = fsize_reg;
        fin_next      = fin_reg;
        ack_next      = ack_reg;
        rpend_next    = rpend_reg;
        push          = 1'b0;
        push_cmd      = '0;
        div_start     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (acc)
                begin
                    unique case (kind) inside
                        KIND_RRQ, KIND_WRQ:
                        begin
                            // Drop the old session.
                            mode_next     = MODE_IDLE;
                            bs_next       = BLK_DEF;
                            ws_next       = WIN_DEF;
                            lack_next     = '0;
                            lwr_next      = '0;
                            fsent_next    = 1'b0;
                            wrap_next     = '0;
                            fin_flag_next = 1'b0;
                            fsize_next    = '0;
                            if (open_status != OST_OK)
                            begin
                                push = 1'b1;
                                if (open_status == OST_ACCESS)
                                    push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_ACCESS,
                                                        '0, '0, '0, 1'b0);
                                else if (kind == KIND_RRQ && open_status == OST_NOT_FOUND)
                                    push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_NOT_FOUND,
                                                        '0, '0, '0, 1'b0);
                                else if (kind == KIND_WRQ && open_status == OST_EXISTS)
                                    push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_EXISTS,
                                                        '0, '0, '0, 1'b0);
                                else
                                    push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_UNDEF,
                                                        '0, '0, '0, 1'b0);
                            end
                            else
                            begin
                                bs_next = nb;
                                ws_next = nw;
                                if (any_opt)
                                begin
                                    push     = 1'b1;
                                    push_cmd = ctrl_cmd(PT_OACK, '0, '0, ob, ow, ot, 1'b0);
                                end
                                if (kind == KIND_RRQ)
                                begin
                                    mode_next  = MODE_READ;
                                    fsize_next = file_length;
                                    ack_next   = '0;
                                    rpend_next = !any_opt;
                                    div_start  = 1'b1;
                                    state_next = F_DIV;
                                end
                                else
                                begin
                                    mode_next = MODE_WRITE;
                                    if (!any_opt)
                                    begin
                                        push     = 1'b1;
                                        push_cmd = ctrl_cmd(PT_ACK, '0, '0, '0, '0, '0, 1'b0);
                                    end
                                end
                            end
                        end
                        KIND_DATA:
                        begin
                            if (mode_reg != MODE_WRITE)
                            begin
                                push     = 1'b1;
                                push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_ILLEGAL,
                                                    '0, '0, '0, fin_flag_reg);
                            end
                            else if (block_number == lwr_inc)
                            begin
                                if (write_status != WST_OK)
                                begin
                                    push     = 1'b1;
                                    push_cmd = ctrl_cmd(PT_ERROR, '0,
                                        (write_status == WST_QUOTA) ? ERR_DISK_FULL : ERR_UNDEF,
                                        '0, '0, '0, fin_flag_reg);
                                end
                                else
                                begin
                                    fin_flag_next = wdone;
                                    lwr_next      = lwr_inc;
                                    if (wack)
                                    begin
                                        lack_next = lwr_inc;
                                        push      = 1'b1;
                                        push_cmd  = ctrl_cmd(PT_ACK, lwr_inc, '0,
                                                             '0, '0, '0, wdone);
                                    end
                                end
                            end
                        end
                        KIND_ACK:
                        begin
                            if (mode_reg != MODE_READ)
                            begin
                                push     = 1'b1;
                                push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_ILLEGAL,
                                                    '0, '0, '0, fin_flag_reg);
                            end
                            else
                            begin
                                ack_next   = block_number;
                                state_next = F_RACK;
                            end
                        end
                        KIND_TICK:
                        begin
                            // Retransmit from the last acknowledged block.
                            if (mode_reg == MODE_READ && !fin_flag_reg)
                            begin
                                ack_next   = lack_reg;
                                state_next = F_RACK;
                            end
                        end
                        default:
                        begin
                            push     = 1'b1;
                            push_cmd = ctrl_cmd(PT_ERROR, '0, ERR_ILLEGAL,
                                                '0, '0, '0, fin_flag_reg);
                        end
                    endcase
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    fin_next   = div_quo[23:0] + 24'd1;
                    state_next = rpend_reg ? F_RACK : F_IDLE;
                end
            end
            F_RACK:
            begin
                if (rcnt == 7'd0 || !q_full)
                begin
                    wrap_next     = rwrap;
                    lack_next     = ack_reg;
                    fin_flag_next = rdone;
                    fsent_next    = fsent_reg || reach_fin;
                    push          = (rcnt != 7'd0);
                    push_cmd      = wcmd;
                    state_next    = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            mode_reg     <= MODE_IDLE;
            bs_reg       <= BLK_DEF;
            ws_reg       <= WIN_DEF;
            lack_reg     <= '0;
            lwr_reg      <= '0;
            fsent_reg    <= 1'b0;
            wrap_reg     <= '0;
            fin_flag_reg <= 1'b0;
            fsize_reg    <= '0;
            fin_reg      <= 24'd1;
            rpend_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            bs_reg       <= bs_next;
            ws_reg       <= ws_next;
            lack_reg     <= lack_next;
            lwr_reg      <= lwr_next;
            fsent_reg    <= fsent_next;
            wrap_reg     <= wrap_next;
            fin_flag_reg <= fin_flag_next;
            fsize_reg    <= fsize_next;
            fin_reg      <= fin_next;
            rpend_reg    <= rpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg <= ack_next;
    end
endmodule

// ----- rtl/core/tws_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on tws_pkg for the command type.
module tws_queue
    import tws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);
    cmd_t       q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= push_cmd;
    end
endmodule

// ----- rtl/core/tws_back.sv -----
// Back end: turns queued commands into result words and a DATA window into one
// descriptor per unstalled cycle. Depends on tws_pkg and the assertion header.
`include "tftp_windowed_session_assert.svh"
module tws_back
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  packet_type,
    output logic [15:0] out_block,
    output logic [2:0]  error_code,
    output logic [31:0] file_offset,
    output logic [15:0] payload_length,
    output logic [15:0] oack_blksize,
    output logic [6:0]  oack_windowsize,
    output logic [7:0]  oack_timeout,
    output logic        session_done,
    output logic        last
);
    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_EMIT = 3'b100
    } bstate_t;

    bstate_t     state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] off_reg, off_next;
    logic [23:0] abs_reg, abs_next;
    logic [6:0]  k_reg, k_next;

    logic        ov_reg, ov_next;
    logic [1:0]  pt_reg, pt_next;
    logic [15:0] blk_reg, blk_next;
    logic [2:0]  err_reg, err_next;
    logic [31:0] fo_reg, fo_next;
    logic [15:0] pl_reg, pl_next;
    logic [15:0] ob_reg, ob_next;
    logic [6:0]  ow_reg, ow_next;
    logic [7:0]  ot_reg, ot_next;
    logic        dn_reg, dn_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic [39:0] prod;
    logic [31:0] tail_len;

    assign out_free = !ov_reg || !out_stall;
    assign prod     = {16'd0, cmd_reg.abs_ack} * {24'd0, cmd_reg.bsize};
    assign tail_len = cmd_reg.fsize - off_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        off_next   = off_reg;
        abs_next   = abs_reg;
        k_next     = k_reg;
        ov_next    = (ov_reg && !out_stall) ? 1'b0 : ov_reg;
        pt_next    = pt_reg;
        blk_next   = blk_reg;
        err_next   = err_reg;
        fo_next    = fo_reg;
        pl_next    = pl_reg;
        ob_next    = ob_reg;
        ow_next    = ow_reg;
        ot_next    = ot_reg;
        dn_next    = dn_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_window)
                    begin
                        q_pop      = 1'b1;
                        cmd_next   = q_cmd;
                        state_next = B_MUL;
                    end
                    else if (out_free)
                    begin
                        q_pop     = 1'b1;
                        ov_next   = 1'b1;
                        pt_next   = q_cmd.ptype;
                        blk_next  = q_cmd.blk;
                        err_next  = q_cmd.err;
                        fo_next   = '0;
                        pl_next   = '0;
                        ob_next   = q_cmd.ob;
                        ow_next   = q_cmd.ow;
                        ot_next   = q_cmd.ot;
                        dn_next   = q_cmd.done;
                        last_next = 1'b1;
                    end
                end
            end
            B_MUL:
            begin
                // Offset of the first block in the window.
                off_next   = prod[31:0];
                abs_next   = cmd_reg.abs_ack + 24'd1;
                k_next     = 7'd1;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    pt_next   = PT_DATA;
                    blk_next  = abs_reg[15:0];
                    err_next  = '0;
                    fo_next   = off_reg;
                    pl_next   = (abs_reg == cmd_reg.fin) ? tail_len[15:0] : cmd_reg.bsize;
                    ob_next   = '0;
                    ow_next   = '0;
                    ot_next   = '0;
                    dn_next   = cmd_reg.done;
                    last_next = (k_reg == cmd_reg.count);
                    off_next  = off_reg + {16'd0, cmd_reg.bsize};
                    abs_next  = abs_reg + 24'd1;
                    k_next    = k_reg + 7'd1;
                    if (k_reg == cmd_reg.count)
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        off_reg  <= off_next;
        abs_reg  <= abs_next;
        k_reg    <= k_next;
        pt_reg   <= pt_next;
        blk_reg  <= blk_next;
        err_reg  <= err_next;
        fo_reg   <= fo_next;
        pl_reg   <= pl_next;
        ob_reg   <= ob_next;
        ow_reg   <= ow_next;
        ot_reg   <= ot_next;
        dn_reg   <= dn_next;
        last_reg <= last_next;
    end

    assign out_valid       = ov_reg;
    assign packet_type     = pt_reg;
    assign out_block       = blk_reg;
    assign error_code      = err_reg;
    assign file_offset     = fo_reg;
    assign payload_length  = pl_reg;
    assign oack_blksize    = ob_reg;
    assign oack_windowsize = ow_reg;
    assign oack_timeout    = ot_reg;
    assign session_done    = dn_reg;
    assign last            = last_reg;

    `TWS_ASSERT_IMP(a_ctrl_last, ov_reg && pt_reg != PT_DATA, last_reg, "control word not last")
    `TWS_ASSERT_IMP(a_ctrl_zero, ov_reg && pt_reg != PT_DATA, fo_reg == 32'd0 && pl_reg == 16'd0, "control word carries DATA fields")
    `TWS_ASSERT_IMP(a_k_bound, state_reg == B_EMIT, k_reg != 7'd0 && k_reg <= cmd_reg.count, "window index out of range")
    `TWS_ASSERT_NEXT(a_mul_emit, state_reg == B_MUL, state_reg == B_EMIT, "multiply step not followed by emit")
endmodule

// ----- rtl/core/tftp_windowed_session.sv -----
// A control word (ERROR, ACK, OACK) is queued on accept, then registered out by
// the back end. A read request stalls the input during a serial divide for the
// final block number; a DATA window then passes the queue and the B_MUL step and
// emits one descriptor per cycle while not stalled, up to the negotiated window.
// ACK and timeout ticks pass F_RACK in the front end, which waits for queue room.
// Reset: limits go to their maxima, the session returns to idle with defaults.
module tftp_windowed_session
    import tws_pkg::*;
#(
    parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // packet input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] block_number,
    input  logic [15:0] data_length,
    input  logic [15:0] req_blksize,
    input  logic [15:0] req_windowsize,
    input  logic [15:0] req_timeout,
    input  logic [2:0]  open_status,
    input  logic [31:0] file_length,
    input  logic [1:0]  write_status,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  packet_type,
    output logic [15:0] out_block,
    output logic [2:0]  error_code,
    output logic [31:0] file_offset,
    output logic [15:0] payload_length,
    output logic [15:0] oack_blksize,
    output logic [6:0]  oack_windowsize,
    output logic [7:0]  oack_timeout,
    output logic        session_done,
    output logic        last
);
    logic [15:0] lim_bs_reg, lim_bs_next;
    logic [6:0]  lim_win_reg, lim_win_next;
    logic [7:0]  lim_tmo_reg, lim_tmo_next;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_in, q_head;

    // Limits are raw register values; the front end clamps them on use.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        lim_bs_next  = lim_bs_reg;
        lim_win_next = lim_win_reg;
        lim_tmo_next = lim_tmo_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LIMIT_BLOCK:   lim_bs_next  = cfg_data;
                CFG_LIMIT_WINDOW:  lim_win_next = cfg_data[6:0];
                CFG_LIMIT_TIMEOUT: lim_tmo_next = cfg_data[7:0];
                default:           lim_bs_next  = lim_bs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_bs_reg  <= BLK_MAX;
            lim_win_reg <= 7'd64;
            lim_tmo_reg <= TMO_MAX;
        end
        else
        begin
            lim_bs_reg  <= lim_bs_next;
            lim_win_reg <= lim_win_next;
            lim_tmo_reg <= lim_tmo_next;
        end
    end

    // Front: classify packets, hold session state, queue commands.
    tws_front #(
        .WINDOW_LIMIT (WINDOW_LIMIT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .block_number   (block_number),
        .data_length    (data_length),
        .req_blksize    (req_blksize),
        .req_windowsize (req_windowsize),
        .req_timeout    (req_timeout),
        .open_status    (open_status),
        .file_length    (file_length),
        .write_status   (write_status),
        .lim_bs         (lim_bs_reg),
        .lim_win        (lim_win_reg),
        .lim_tmo        (lim_tmo_reg),
        .q_full         (q_full),
        .push           (q_push),
        .push_cmd       (q_in)
    );

    // Queue: decouple command generation from word emission.
    tws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back: emit control words and expand DATA windows.
    tws_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .packet_type     (packet_type),
        .out_block       (out_block),
        .error_code      (error_code),
        .file_offset     (file_offset),
        .payload_length  (payload_length),
        .oack_blksize    (oack_blksize),
        .oack_windowsize (oack_windowsize),
        .oack_timeout    (oack_timeout),
        .session_done    (session_done),
        .last            (last)
    );
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for tftp_windowed_session: drives packet words and
// limit writes, predicts every result word and checks them in order.
// Depends on tws_pkg and the tftp_windowed_session RTL.
module testbench;
    import tws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package does not name.
    localparam logic [2:0] KIND_BAD  = 3'd5;
    localparam logic [2:0] KIND_RSV6 = 3'd6;
    localparam logic [2:0] KIND_RSV7 = 3'd7;
    localparam logic [2:0] OST_OTHER = 3'd4;
    localparam logic [1:0] WST_OTHER = 2'd2;
    localparam int         WIN_CAP   = 64;
    localparam int         SETTLE    = 140;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] blk;
        logic [15:0] dlen;
        logic [15:0] rb;
        logic [15:0] rw;
        logic [15:0] rt;
        logic [2:0]  ost;
        logic [31:0] flen;
        logic [1:0]  wst;
    } pkt_word_t;

    typedef struct {
        logic [1:0]  ptype;
        logic [15:0] blk;
        logic [2:0]  err;
        logic [31:0] off;
        logic [15:0] len;
        logic [15:0] ob;
        logic [6:0]  ow;
        logic [7:0]  ot;
        logic        done;
        logic        fin_word;
    } result_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [15:0] block_number;
    logic [15:0] data_length;
    logic [15:0] req_blksize;
    logic [15:0] req_windowsize;
    logic [15:0] req_timeout;
    logic [2:0]  open_status;
    logic [31:0] file_length;
    logic [1:0]  write_status;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  packet_type;
    logic [15:0] out_block;
    logic [2:0]  error_code;
    logic [31:0] file_offset;
    logic [15:0] payload_length;
    logic [15:0] oack_blksize;
    logic [6:0]  oack_windowsize;
    logic [7:0]  oack_timeout;
    logic        session_done;
    logic        last;

    tftp_windowed_session u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .block_number   (block_number),
        .data_length    (data_length),
        .req_blksize    (req_blksize),
        .req_windowsize (req_windowsize),
        .req_timeout    (req_timeout),
        .open_status    (open_status),
        .file_length    (file_length),
        .write_status   (write_status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .packet_type    (packet_type),
        .out_block      (out_block),
        .error_code     (error_code),
        .file_offset    (file_offset),
        .payload_length (payload_length),
        .oack_blksize   (oack_blksize),
        .oack_windowsize(oack_windowsize),
        .oack_timeout   (oack_timeout),
        .session_done   (session_done),
        .last           (last)
    );

    // ------------------------------------------------------------------
    // Session model: limits, negotiated options and transfer progress.
    // ------------------------------------------------------------------
    logic [15:0]     lim_blk;
    logic [6:0]      lim_win;
    logic [7:0]      lim_tmo;
    mode_t           smode;
    int unsigned     bsz, wsz, tsecs;
    int unsigned     acked_blk, written_blk, wrapc;
    int unsigned     final_mark;   // bit 16 set once the final block went out
    bit              done_flag;
    longint unsigned fsize;
    logic [15:0]     newest_data;  // newest DATA block predicted, steers ACKs

    result_word_t staged[$];
    result_word_t expected_words[$];
    int           mismatches;

    // Stimulus pacing.
    int  burst_left;
    bit  steady_in;
    bit  steady_out;
    int  stall_pct;
    int  hold_cycles;

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void stage_word(logic [1:0] pt, logic [15:0] blk, logic [2:0] err,
                                       logic [31:0] off, logic [15:0] len, logic [15:0] ob,
                                       logic [6:0] ow, logic [7:0] ot);
        result_word_t r;
        r = '{pt, blk, err, off, len, ob, ow, ot, 1'b0, 1'b0};
        staged.insert(staged.size(), r);
        if (pt == PT_DATA)
            newest_data = blk;
    endfunction

    function automatic void clear_session();
        smode       = MODE_IDLE;
        bsz         = 512;
        wsz         = 1;
        tsecs       = 1;
        acked_blk   = 0;
        written_blk = 0;
        final_mark  = 0;
        wrapc       = 0;
        done_flag   = 0;
        fsize       = 0;
    endfunction

    // Advance the read side on an acknowledgement and emit the next window.
    function automatic void serve_ack(int unsigned ack);
        int unsigned     d;
        longint unsigned abs_ack, fin, blk_abs, off;
        int unsigned     k;
        d = (ack - acked_blk) & 16'hFFFF;
        if (d != 0 && d < 32768)
        begin
            if (ack < acked_blk)
                wrapc = (wrapc + 1) & 8'hFF;
        end
        else if (d >= 32768)
        begin
            if (ack > acked_blk && wrapc > 0)
                wrapc = wrapc - 1;
        end
        acked_blk = ack & 16'hFFFF;
        abs_ack   = longint'(wrapc) * 65536 + acked_blk;
        fin       = fsize / bsz + 1;
        if (final_mark[16] && abs_ack == fin)
            done_flag = 1;
        for (k = 1; k <= wsz && k <= WIN_CAP; k++)
        begin
            blk_abs = abs_ack + k;
            if (blk_abs > fin)
                break;
            off = (blk_abs - 1) * bsz;
            stage_word(PT_DATA, blk_abs[15:0], ERR_UNDEF, off[31:0],
                       (blk_abs == fin) ? 16'(fsize - off) : 16'(bsz), '0, '0, '0);
            if (blk_abs == fin)
            begin
                final_mark = 32'h10000 | blk_abs[15:0];
                break;
            end
        end
    endfunction

    // Work out every result one accepted word causes and queue them.
    function automatic void predict_session(pkt_word_t w);
        logic [2:0]  err;
        int unsigned ob, ow, ot;
        int unsigned lb, lw, lt;
        int unsigned i;
        staged.delete();
        lb = clamp_u(lim_blk, 512, 65464);
        lw = clamp_u(lim_win, 1, WIN_CAP);
        lt = clamp_u(lim_tmo, 1, 255);
        if (w.kind == KIND_RRQ || w.kind == KIND_WRQ)
        begin
            clear_session();
            if (w.ost != OST_OK)
            begin
                if (w.ost == OST_ACCESS)                               err = ERR_ACCESS;
                else if (w.kind == KIND_RRQ && w.ost == OST_NOT_FOUND) err = ERR_NOT_FOUND;
                else if (w.kind == KIND_WRQ && w.ost == OST_EXISTS)    err = ERR_EXISTS;
                else                                                   err = ERR_UNDEF;
                stage_word(PT_ERROR, '0, err, '0, '0, '0, '0, '0);
            end
            else
            begin
                ob = 0; ow = 0; ot = 0;
                if (w.rb > 512)
                begin
                    bsz = w.rb < lb ? w.rb : lb;
                    ob  = bsz;
                end
                if (w.rw > 1)
                begin
                    wsz = w.rw < lw ? w.rw : lw;
                    ow  = wsz;
                end
                if (w.rt > 1)
                begin
                    tsecs = w.rt < lt ? w.rt : lt;
                    ot    = tsecs;
                end
                if (w.kind == KIND_RRQ)
                begin
                    smode = MODE_READ;
                    fsize = w.flen;
                    if (ob != 0 || ow != 0 || ot != 0)
                        stage_word(PT_OACK, '0, '0, '0, '0, ob[15:0], ow[6:0], ot[7:0]);
                    else
                        serve_ack(0);
                end
                else
                begin
                    smode = MODE_WRITE;
                    if (ob != 0 || ow != 0 || ot != 0)
                        stage_word(PT_OACK, '0, '0, '0, '0, ob[15:0], ow[6:0], ot[7:0]);
                    else
                        stage_word(PT_ACK, '0, '0, '0, '0, '0, '0, '0);
                end
            end
        end
        else if (w.kind == KIND_DATA)
        begin
            if (smode != MODE_WRITE)
                stage_word(PT_ERROR, '0, ERR_ILLEGAL, '0, '0, '0, '0, '0);
            else if (w.blk == 16'(written_blk + 1))
            begin
                if (w.wst != WST_OK)
                    stage_word(PT_ERROR, '0, (w.wst == WST_QUOTA) ? ERR_DISK_FULL : ERR_UNDEF,
                               '0, '0, '0, '0, '0);
                else
                begin
                    if (w.dlen < bsz)
                        done_flag = 1;
                    written_blk = (written_blk + 1) & 16'hFFFF;
                    if (done_flag || written_blk == ((acked_blk + wsz) & 16'hFFFF))
                    begin
                        acked_blk = written_blk;
                        stage_word(PT_ACK, written_blk[15:0], '0, '0, '0, '0, '0, '0);
                    end
                end
            end
        end
        else if (w.kind == KIND_ACK)
        begin
            if (smode != MODE_READ)
                stage_word(PT_ERROR, '0, ERR_ILLEGAL, '0, '0, '0, '0, '0);
            else
                serve_ack(w.blk);
        end
        else if (w.kind == KIND_TICK)
        begin
            if (smode == MODE_READ && !done_flag)
                serve_ack(acked_blk);
        end
        else
            stage_word(PT_ERROR, '0, ERR_ILLEGAL, '0, '0, '0, '0, '0);

        for (i = 0; i < staged.size(); i++)
        begin
            staged[i].done     = done_flag;
            staged[i].fin_word = (i == staged.size() - 1);
            expected_words.insert(expected_words.size(), staged[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit and receiver
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: hold off for a counted stretch when asked, else stay ready if
    // steady_out is set, else stall at a random rate that drifts now and then.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (steady_out)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        if ($urandom_range(0, 63) == 0)
            stall_pct <= $urandom_range(0, 80);
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        result_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: type %0d block %0d", packet_type, out_block);
            end
            else
            begin
                e = expected_words.pop_front();
                if (packet_type !== e.ptype || out_block !== e.blk || error_code !== e.err ||
                    file_offset !== e.off || payload_length !== e.len ||
                    oack_blksize !== e.ob || oack_windowsize !== e.ow ||
                    oack_timeout !== e.ot || session_done !== e.done || last !== e.fin_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"exp: type %0d blk %0d err %0d off %0d len %0d",
                                  " oack %0d/%0d/%0d done %0d last %0d"},
                                 e.ptype, e.blk, e.err, e.off, e.len, e.ob, e.ow, e.ot,
                                 e.done, e.fin_word);
                        $display({"got: type %0d blk %0d err %0d off %0d len %0d",
                                  " oack %0d/%0d/%0d done %0d last %0d"},
                                 packet_type, out_block, error_code, file_offset,
                                 payload_length, oack_blksize, oack_windowsize,
                                 oack_timeout, session_done, last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Send one word, wait for it to be taken, then maybe idle for a gap.
    task automatic send_word(pkt_word_t w);
        int gap;
        @(negedge clk);
        kind           <= w.kind;
        block_number   <= w.blk;
        data_length    <= w.dlen;
        req_blksize    <= w.rb;
        req_windowsize <= w.rw;
        req_timeout    <= w.rt;
        open_status    <= w.ost;
        file_length    <= w.flen;
        write_status   <= w.wst;
        in_valid       <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_session(w);
        if (burst_left > 0 || steady_in)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Drop valid so the held word is not taken again.
    task automatic park_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait for every expected word, then let a trailing window drain.
    task automatic drain();
        int guard;
        park_input();
        guard = 0;
        while (expected_words.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_LIMIT_BLOCK)        lim_blk = value;
        else if (idx == CFG_LIMIT_WINDOW)  lim_win = value[6:0];
        else if (idx == CFG_LIMIT_TIMEOUT) lim_tmo = value[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(logic [15:0] b, logic [15:0] wn, logic [15:0] t);
        drain();
        write_limit(CFG_LIMIT_BLOCK, b);
        write_limit(CFG_LIMIT_WINDOW, wn);
        write_limit(CFG_LIMIT_TIMEOUT, t);
    endtask

    function automatic pkt_word_t mk(logic [2:0] k, logic [15:0] blk = '0,
                                     logic [15:0] dlen = '0, logic [15:0] rb = '0,
                                     logic [15:0] rw = '0, logic [15:0] rt = '0,
                                     logic [2:0] ost = OST_OK, logic [31:0] flen = '0,
                                     logic [1:0] wst = WST_OK);
        pkt_word_t w;
        w = '{k, blk, dlen, rb, rw, rt, ost, flen, wst};
        return w;
    endfunction

    function automatic pkt_word_t noise_word();
        return mk(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 3'($urandom), $urandom, 2'($urandom));
    endfunction

    // Random option value: absent, at default, just over, mid or huge.
    function automatic logic [15:0] pick_option(int dflt);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'(dflt);
            2:       return 16'(dflt + 1);
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(dflt, dflt * 4 + 8));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Open failures, illegal operations, option edges and empty files.
    task automatic test_directed();
        int s;
        for (s = 0; s < 8; s++)
        begin
            send_word(mk(KIND_RRQ, 0, 0, 0, 0, 0, s[2:0]));
            send_word(mk(KIND_WRQ, 0, 0, 0, 0, 0, s[2:0]));
        end
        send_word(mk(KIND_DATA, 1, 512));
        send_word(mk(KIND_ACK, 1));
        send_word(mk(KIND_TICK));
        send_word(mk(KIND_BAD, 16'hFFFF, 16'hFFFF));
        send_word(mk(KIND_RSV6));
        send_word(mk(KIND_RSV7));
        // Options at default are ignored, empty file sends one empty block.
        send_word(mk(KIND_RRQ, 0, 0, 512, 1, 1, OST_OK, 0));
        send_word(mk(KIND_ACK, 1));
        send_word(mk(KIND_TICK));
        send_word(mk(KIND_WRQ, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(mk(KIND_ACK, 0));
        send_word(mk(KIND_DATA, 1, 16'hFFFF));
        send_word(mk(KIND_RRQ, 0, 0, 513, 2, 2, OST_OK, 32'hFFFF_FFFF));
        drain();
    endtask

    // In-order upload with window ACKs, stray blocks, store failures and a
    // short final block.
    task automatic write_session(int blocks);
        int n;
        logic [15:0] nb;
        send_word(mk(KIND_WRQ, 0, 0, pick_option(512), pick_option(1), pick_option(1),
                     ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : OST_OK));
        for (n = 0; n < blocks; n++)
        begin
            nb = 16'(written_blk + 1);
            if ($urandom_range(0, 9) == 0)
                nb = 16'($urandom);
            send_word(mk(KIND_DATA, nb, 16'(bsz + $urandom_range(0, 3)), 0, 0, 0, OST_OK, 0,
                         ($urandom_range(0, 11) == 0) ? 2'($urandom_range(1, 3)) : WST_OK));
        end
        send_word(mk(KIND_DATA, 16'(written_blk + 1), 16'($urandom_range(0, bsz - 1))));
    endtask

    // Download driven by ACKs of the newest block, with ticks and stale ACKs.
    task automatic read_session(int acks, logic [15:0] rb, logic [15:0] rw);
        int n;
        int unsigned span;
        span = (rb > 512) ? rb : 512;
        send_word(mk(KIND_RRQ, 0, 0, rb, rw, pick_option(1),
                     ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : OST_OK,
                     $urandom_range(0, 40) * span + $urandom_range(0, span)));
        newest_data = 0;
        for (n = 0; n < acks && !done_flag; n++)
        begin
            case ($urandom_range(0, 9))
                0:       send_word(mk(KIND_TICK));
                1:       send_word(mk(KIND_ACK, 16'(acked_blk)));
                2:       send_word(mk(KIND_ACK, 16'($urandom)));
                default: send_word(mk(KIND_ACK, newest_data));
            endcase
        end
        if (smode == MODE_READ)
            send_word(mk(KIND_ACK, newest_data));
    endtask

    // Block numbers that cross 65535 forward and then back.
    task automatic test_wraparound();
        send_word(mk(KIND_RRQ, 0, 0, 0, 4, 0, OST_OK, 32'hFFFF_FFFF));
        send_word(mk(KIND_ACK, 65533));
        send_word(mk(KIND_ACK, 65535));
        send_word(mk(KIND_ACK, 2));
        send_word(mk(KIND_TICK));
        send_word(mk(KIND_ACK, 65535));
        send_word(mk(KIND_ACK, 2));
        drain();
    endtask

    // Hold the receiver for a long stretch while large windows pile up.
    task automatic test_backpressure();
        int n;
        hold_cycles = 600;
        steady_in   = 1;
        send_word(mk(KIND_RRQ, 0, 0, 600, 64, 0, OST_OK, 32'h0100_0000));
        newest_data = 0;
        for (n = 0; n < 12; n++)
            send_word(mk(KIND_ACK, newest_data));
        steady_in = 0;
        drain();
    endtask

    // Mostly well-formed sessions with random content, some raw noise.
    task automatic test_random(int items);
        int start_cnt;
        int sent;
        sent = 0;
        while (sent < items)
        begin
            steady_in  = ($urandom_range(0, 3) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    start_cnt = $urandom_range(2, 14);
                    write_session(start_cnt);
                    sent += start_cnt + 2;
                end
                2, 3, 4:
                begin
                    start_cnt = $urandom_range(2, 14);
                    read_session(start_cnt, pick_option(512), pick_option(1));
                    sent += start_cnt + 2;
                end
                default:
                begin
                    send_word(noise_word());
                    sent++;
                end
            endcase
        end
        steady_in  = 0;
        steady_out = 0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = '0;
        block_number   = '0;
        data_length    = '0;
        req_blksize    = '0;
        req_windowsize = '0;
        req_timeout    = '0;
        open_status    = '0;
        file_length    = '0;
        write_status   = '0;
        out_stall      = 1'b0;
        mismatches     = 0;
        burst_left     = 0;
        steady_in      = 0;
        steady_out     = 0;
        stall_pct      = 30;
        hold_cycles    = 0;
        lim_blk        = 16'd65464;
        lim_win        = 7'd64;
        lim_tmo        = 8'd255;
        newest_data    = 0;
        clear_session();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_wraparound();
        test_random(25);
        // Tightest legal limits.
        set_limits(16'd512, 16'd1, 16'd1);
        test_random(15);
        // Out-of-range limits clamp at both ends.
        set_limits(16'd0, 16'd0, 16'd0);
        test_random(15);
        set_limits(16'hFFFF, 16'd127, 16'd255);
        test_backpressure();
        test_random(20);
        set_limits(16'($urandom_range(512, 4096)), 16'($urandom_range(2, 16)),
                   16'($urandom_range(2, 60)));
        test_random(20);
        drain();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_div.sv
rtl/core/tws_front.sv
rtl/core/tws_queue.sv
rtl/core/tws_back.sv
rtl/core/tftp_windowed_session.sv
tb/sv/testbench.sv
